FILE: rtl/ufbd_pkg.sv
// Shared types and constants for the UART fractional baud divisor search.
// Used by the channel interfaces, the serial divider and the top level.
package ufbd_pkg;

  localparam int BAUD_W     = 22;
  localparam int SYSCLK_W   = 28;
  localparam int PCT_W      = 7;
  localparam int DIVISOR_W  = 16;
  localparam int FRAC_W     = 4;
  localparam int ERR_W      = 17;

  // The sampling clock is the system clock divided by four and then sixteen.
  localparam int CLK_SHIFT  = 6;
  localparam int SCLK_W     = SYSCLK_W - CLK_SHIFT;
  localparam int DVD_W      = SCLK_W + FRAC_W;
  localparam int CNT_W      = $clog2(DVD_W);
  localparam int ACC_W      = BAUD_W + PCT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SYSCLK_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SYSCLK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT    = 2'd1;

  localparam logic [SYSCLK_W-1:0] SYSCLK_RESET = 28'd100000000;
  localparam logic [PCT_W-1:0]    PCT_RESET    = 7'd3;
  localparam logic [ERR_W-1:0]    ERROR_LIMIT  = 17'd100000;
  localparam logic [FRAC_W-1:0]   FRAC_MAX     = 4'd15;
  localparam logic [FRAC_W-1:0]   MUL_FIRST    = 4'd1;
  localparam logic [DVD_W:0]      DIV_MIN      = (DVD_W+1)'(3);
  localparam logic [ACC_W-1:0]    PCT_SCALE    = ACC_W'(100);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_T_GO,
    ST_T_WAIT,
    ST_D_GO,
    ST_D_WAIT,
    ST_C_GO,
    ST_C_WAIT,
    ST_NEXT,
    ST_FIN,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVD_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/ufbd_if.sv
// Valid/ready channel interfaces: baud request, search result and register write.
// Depends on ufbd_pkg for field widths.
interface ufbd_in_if import ufbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BAUD_W-1:0] baud_rate;

  modport source (output valid, output baud_rate, input ready);
  modport sink   (input valid, input baud_rate, output ready);
endinterface

interface ufbd_out_if import ufbd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [DIVISOR_W-1:0] divisor;
  logic [FRAC_W-1:0]    mul_val;
  logic [FRAC_W-1:0]    add_val;

  modport source (output valid, output accepted, output divisor, output mul_val,
                  output add_val, input ready);
  modport sink   (input valid, input accepted, input divisor, input mul_val,
                  input add_val, output ready);
endinterface

interface ufbd_cfg_if import ufbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ufbd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on ufbd_pkg for the request and response structs.
module ufbd_divider import ufbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvs_q;
  logic [DVD_W-1:0] quot_q;
  logic [DVD_W-1:0] rem_q;
  logic [DVD_W:0]   shifted;
  logic [DVD_W:0]   trial;
  logic             fits;

  // The dividend shifts out of the quotient register as quotient bits shift in.
  assign shifted = {rem_q, quot_q[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q  <= req_i.divisor;
      quot_q <= req_i.dividend;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[DVD_W-2:0], fits};
      rem_q  <= fits ? trial[DVD_W-1:0] : shifted[DVD_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: rtl/uart_fractional_baud_divisor_search_core.sv
// Top level of the UART fractional baud divisor search: sequencer, config registers
// and candidate bookkeeping. Depends on ufbd_pkg, ufbd_if.sv and ufbd_divider.
//
// Usage: a beat on in_if carries a requested baud rate. The block walks the
// multiplier 1..15 and divisor-add 0..15 pairs; for each pair it forms
// t = mul * (sysclk / 64) / (mul + add), the rounded divisor d = t / baud and
// the achieved rate t / d, all three divisions on one 26-bit serial divider;
// a pair whose d falls outside 3..65535 skips the third division. The search
// ends early at the first exact match. A zero baud rate skips the search and
// presents its result in the cycle right after the request beat.
// One beat on out_if returns accepted, divisor, mul_val and add_val. in_if is
// not ready from the accepted beat until the result beat has been taken; a
// stalled result simply holds on out_if. cfg_if is always ready and writes
// system_clock_hz (index 0) or accepted_error_percent (index 1); write only while
// idle. Reset restores 100 MHz and 3 percent and returns the block to idle.
module uart_fractional_baud_divisor_search_core import ufbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ufbd_in_if.sink    in_if,
  ufbd_out_if.source out_if,
  ufbd_cfg_if.sink   cfg_if
);

  state_e state_q, state_d;

  logic [SYSCLK_W-1:0]  sysclk_q;
  logic [PCT_W-1:0]     pct_q;
  logic [BAUD_W-1:0]    baud_q;
  logic [SCLK_W-1:0]    sclk_q;
  logic [FRAC_W-1:0]    mul_q;
  logic [FRAC_W-1:0]    add_q;
  logic [DVD_W-1:0]     prod_q;
  logic [DVD_W-1:0]     t_q;
  logic [DIVISOR_W-1:0] d_q;
  logic [ERR_W-1:0]     best_err_q;
  logic [DIVISOR_W-1:0] best_div_q;
  logic [FRAC_W-1:0]    best_mul_q;
  logic [FRAC_W-1:0]    best_add_q;
  logic                 found_q;
  logic [ACC_W-1:0]     lim_q;
  logic [ACC_W-1:0]     scaled_q;
  logic                 acc_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic           in_fire;
  logic           last_pair;
  logic           round_up;
  logic [DVD_W:0] d_c;
  logic           d_valid;
  logic [DVD_W-1:0] baud_ext;
  logic [DVD_W-1:0] err_c;
  logic           better;

  ufbd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_fire   = in_if.valid && in_if.ready;
  assign last_pair = (mul_q == FRAC_MAX) && (add_q == FRAC_MAX);

  // Rounding: bump the divisor when the remainder exceeds half the baud rate.
  assign baud_ext = DVD_W'(baud_q);
  assign round_up = div_rsp.rem > DVD_W'(baud_q >> 1);
  assign d_c      = {1'b0, div_rsp.quot} + (DVD_W+1)'(round_up);
  assign d_valid  = (d_c[DVD_W:DIVISOR_W] == '0) && (d_c >= DIV_MIN);

  assign err_c  = (div_rsp.quot <= baud_ext) ? baud_ext - div_rsp.quot
                                             : div_rsp.quot - baud_ext;
  assign better = err_c < DVD_W'(best_err_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = (in_if.baud_rate == '0) ? ST_OUT : ST_PROD;
      end
      ST_PROD:   state_d = ST_T_GO;
      ST_T_GO:   state_d = ST_T_WAIT;
      ST_T_WAIT: if (div_rsp.done) state_d = ST_D_GO;
      ST_D_GO:   state_d = ST_D_WAIT;
      ST_D_WAIT: begin
        if (div_rsp.done) state_d = d_valid ? ST_C_GO : ST_NEXT;
      end
      ST_C_GO:   state_d = ST_C_WAIT;
      ST_C_WAIT: if (div_rsp.done) state_d = ST_NEXT;
      ST_NEXT:   state_d = (found_q || last_pair) ? ST_FIN : ST_PROD;
      ST_FIN:    state_d = ST_ACC;
      ST_ACC:    state_d = ST_OUT;
      ST_OUT:    if (out_if.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready         = 1'b0;
    out_if.valid        = 1'b0;
    div_req.start       = 1'b0;
    div_req.dividend    = t_q;
    div_req.divisor     = DVD_W'(d_q);
    case (state_q)
      ST_IDLE: in_if.ready = 1'b1;
      ST_T_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = DVD_W'({1'b0, mul_q} + {1'b0, add_q});
      end
      ST_D_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = baud_ext;
      end
      ST_C_GO: div_req.start = 1'b1;
      ST_OUT:  out_if.valid  = 1'b1;
      default: ;
    endcase
  end

  assign cfg_if.ready   = 1'b1;
  assign out_if.accepted = acc_q;
  assign out_if.divisor  = best_div_q;
  assign out_if.mul_val  = best_mul_q;
  assign out_if.add_val  = best_add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sysclk_q <= SYSCLK_RESET;
      pct_q    <= PCT_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_if.valid && (cfg_if.index == CFG_SYSCLK)) sysclk_q <= cfg_if.data;
      if (cfg_if.valid && (cfg_if.index == CFG_PCT))    pct_q    <= cfg_if.data[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          baud_q     <= in_if.baud_rate;
          sclk_q     <= sysclk_q[SYSCLK_W-1:CLK_SHIFT];
          mul_q      <= MUL_FIRST;
          add_q      <= '0;
          best_err_q <= ERROR_LIMIT;
          best_div_q <= '0;
          best_mul_q <= MUL_FIRST;
          best_add_q <= '0;
          found_q    <= 1'b0;
          acc_q      <= 1'b0;
        end
      end
      ST_PROD:   prod_q <= DVD_W'(mul_q) * DVD_W'(sclk_q);
      ST_T_WAIT: if (div_rsp.done) t_q <= div_rsp.quot;
      ST_D_WAIT: if (div_rsp.done) d_q <= d_c[DIVISOR_W-1:0];
      ST_C_WAIT: begin
        if (div_rsp.done && better) begin
          best_err_q <= err_c[ERR_W-1:0];
          best_div_q <= d_q;
          best_mul_q <= mul_q;
          best_add_q <= add_q;
          found_q    <= (err_c == '0);
        end
      end
      ST_NEXT: begin
        if (add_q == FRAC_MAX) begin
          add_q <= '0;
          mul_q <= mul_q + 1'b1;
        end else begin
          add_q <= add_q + 1'b1;
        end
      end
      ST_FIN: begin
        // best < floor(baud * pct / 100) holds exactly when (best + 1) * 100 <= baud * pct.
        scaled_q <= ACC_W'(baud_q) * ACC_W'(pct_q);
        lim_q    <= (ACC_W'(best_err_q) + 1'b1) * PCT_SCALE;
      end
      ST_ACC:  acc_q <= lim_q <= scaled_q;
      default: ;
    endcase
  end

endmodule

FILE: rtl/ufbd_checker.sv
// Port-level checks for the baud divisor search core, bound to its top level.
// Depends on ufbd_pkg and on the core's interface ports.
module ufbd_checker import ufbd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DIVISOR_W-1:0] out_divisor,
  input logic [FRAC_W-1:0]    out_mul_val
);

  // One request at a time: no new beat is taken right after one was accepted.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // A pending result blocks new requests.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid && in_ready))
    else $error("input ready while a result is pending");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  a_mul_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_mul_val != '0))
    else $error("multiplier value of zero in a result");

  // A divisor is either the no-candidate marker or a valid divisor.
  a_divisor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_divisor != '0)) |-> (out_divisor >= DIVISOR_W'(3)))
    else $error("divisor below three in a result");

endmodule

bind uart_fractional_baud_divisor_search_core ufbd_checker u_ufbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_divisor (out_if.divisor),
  .out_mul_val (out_if.mul_val)
);

FILE: test/tb_uart_fractional_baud_divisor_search_core.sv
// Self-checking testbench for uart_fractional_baud_divisor_search_core: drives baud requests
// and register writes, predicts each divider setting and compares every result beat.
// Depends on rtl/ufbd_pkg.sv, rtl/ufbd_if.sv and the core with its serial divider.
module tb_uart_fractional_baud_divisor_search_core;
  import ufbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 12_000_000;
  localparam longint unsigned DIVISOR_END = 64'd1 << DIVISOR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                 accepted;
    logic [DIVISOR_W-1:0] divisor;
    logic [FRAC_W-1:0]    mul_val;
    logic [FRAC_W-1:0]    add_val;
  } baud_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ufbd_in_if  in_if ();
  ufbd_out_if out_if ();
  ufbd_cfg_if cfg_if ();

  uart_fractional_baud_divisor_search_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copy of the two configuration registers.
  logic [SYSCLK_W-1:0] sysclk_cfg = SYSCLK_RESET;
  logic [PCT_W-1:0]    pct_cfg    = PCT_RESET;

  logic [BAUD_W-1:0] baud_queue[$];
  baud_setting_t     setting_queue[$];
  baud_setting_t     wanted;
  int unsigned       send_gap;
  int unsigned       take_gap;
  int unsigned       errors = 0;
  int unsigned       cycle_count = 0;
  bit                calm = 1'b0;

  int unsigned std_rates[12] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                 115200, 230400, 460800, 921600};

  // Walks every multiplier / divisor-add pair and keeps the first pair with the
  // strictly smallest baud error, stopping at the first exact hit.
  function automatic baud_setting_t predict_setting(logic [BAUD_W-1:0] baud);
    baud_setting_t   best;
    longint unsigned rate, sclk, t, d, calc, err, best_err, m, a;
    bit              hit;
    best.accepted = 1'b0;
    best.divisor  = '0;
    best.mul_val  = MUL_FIRST;
    best.add_val  = '0;
    best_err      = ERROR_LIMIT;
    hit           = 1'b0;
    rate          = baud;
    if (rate != 0) begin
      sclk = sysclk_cfg >> CLK_SHIFT;
      for (m = MUL_FIRST; m <= FRAC_MAX && !hit; m++) begin
        for (a = 0; a <= FRAC_MAX && !hit; a++) begin
          t = (m * sclk) / (m + a);
          d = t / rate;
          if ((t % rate) > (rate / 2)) d++;
          if (d >= DIV_MIN && d < DIVISOR_END) begin
            calc = t / d;
            err  = (calc <= rate) ? rate - calc : calc - rate;
            if (err < best_err) begin
              best_err     = err;
              best.divisor = d[DIVISOR_W-1:0];
              best.mul_val = m[FRAC_W-1:0];
              best.add_val = a[FRAC_W-1:0];
              hit          = (err == 0);
            end
          end
        end
      end
      best.accepted = best_err < (rate * pct_cfg) / PCT_SCALE;
    end
    return best;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Leaves valid high so that back-to-back writes need only one assignment per edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_SYSCLK: sysclk_cfg = value[SYSCLK_W-1:0];
      CFG_PCT:    pct_cfg    = value[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [SYSCLK_W-1:0] clk_hz, logic [PCT_W-1:0] pct);
    logic [CFG_DATA_W-1:0] pct_word;
    // Upper data bits of a percent write carry noise; only the low bits count.
    pct_word = CFG_DATA_W'($urandom);
    pct_word[PCT_W-1:0] = pct;
    write_reg(CFG_SYSCLK, clk_hz);
    write_reg(CFG_PCT, pct_word);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (baud_queue.size() != 0 || in_if.valid || setting_queue.size() != 0)
      @(posedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        setting_queue.push_back(predict_setting(in_if.baud_rate));
      end
      if (in_if.valid && !in_if.ready) begin
        // Beat still pending: hold it.
      end else if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= $urandom_range(0, 6);
      end else if (baud_queue.size() != 0) begin
        in_if.valid     <= 1'b1;
        in_if.baud_rate <= baud_queue.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_gap     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (setting_queue.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          wanted = setting_queue.pop_front();
          check_field("accepted", wanted.accepted, out_if.accepted);
          check_field("divisor", wanted.divisor, out_if.divisor);
          check_field("mul_val", wanted.mul_val, out_if.mul_val);
          check_field("add_val", wanted.add_val, out_if.add_val);
        end
      end
      if (take_gap != 0) begin
        out_if.ready <= 1'b0;
        take_gap     <= take_gap - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        take_gap     <= $urandom_range(0, 6);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SYSCLK_W-1:0] clk_pick;
    logic [PCT_W-1:0]    pct_pick;
    logic [BAUD_W-1:0]   rate_pick;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.baud_rate = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_SYSCLK;
    cfg_if.data     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero rate, an exact first-pair hit, common rates and the extremes.
    baud_queue = '{22'd0, 22'd1, 22'd15625, 22'd9600, 22'd115200, 22'd4000000,
                   22'h3FFFFF, 22'd2};
    drain();

    // Stopped clock: nothing is valid, yet a huge percent still accepts a wide rate.
    set_config('0, 7'd127);
    baud_queue = '{22'h3FFFFF, 22'd9600, 22'd0};
    drain();

    set_config({SYSCLK_W{1'b1}}, 7'd0);
    baud_queue = '{22'd115200, 22'd3000000, 22'd1};
    drain();

    // A clock so slow that every divisor falls below the minimum.
    set_config(28'd100, 7'd100);
    baud_queue = '{22'd1, 22'd300};
    drain();

    // The spare index must not disturb either register.
    write_reg(CFG_SPARE, {CFG_DATA_W{1'b1}});
    write_reg(CFG_SYSCLK, 28'd200000000);
    write_reg(CFG_PCT, CFG_DATA_W'(7'd100));
    write_reg(CFG_SPARE, '0);
    cfg_if.valid <= 1'b0;
    baud_queue = '{22'd921600, 22'd38400};
    drain();

    for (int p = 0; p < 5; p++) begin
      calm = (p == 4);
      case ($urandom_range(0, 4))
        0, 1: clk_pick = SYSCLK_W'($urandom_range(0, 200000000));
        2:    clk_pick = SYSCLK_W'($urandom);
        3:    clk_pick = 28'd100000000;
        default: clk_pick = 28'd1843200 << $urandom_range(0, 6);
      endcase
      pct_pick = ($urandom_range(0, 3) == 0) ? PCT_W'($urandom_range(0, 127))
                                             : PCT_W'($urandom_range(0, 10));
      set_config(clk_pick, pct_pick);
      repeat (20) begin
        case ($urandom_range(0, 19))
          0:           rate_pick = '0;
          1, 2:        rate_pick = BAUD_W'($urandom_range(1, 1000));
          3, 4, 5:     rate_pick = BAUD_W'($urandom);
          6, 7, 8, 9,
          10, 11:      rate_pick = BAUD_W'($urandom_range(1, 4000000));
          default:     rate_pick = BAUD_W'(std_rates[$urandom_range(0, 11)]);
        endcase
        baud_queue.push_back(rate_pick);
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0 && setting_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
